// ===== sv/mrac_pkg.sv =====
// shared types, constants and helpers of the register access checker
// no dependencies
package mrac_pkg;

  localparam int unsigned RegionBytesDef = 4096;
  localparam int unsigned DescSlotsDef   = 5;
  localparam int unsigned DescW          = 43;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 43;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_WIDTH   = 3'd1,
    ST_OUT_REGION  = 3'd2,
    ST_UNKNOWN     = 3'd3,
    ST_MISALIGNED  = 3'd4,
    ST_OUT_REG     = 3'd5,
    ST_DIR_DENIED  = 3'd6
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REGION_BASE = 3'd0,
    CFG_REGION_LAST = 3'd1,
    CFG_DESC_IN_USE = 3'd2,
    CFG_DESC_0      = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        aligned;
    logic [1:0]  dirs;
    logic [3:0]  widths;
    logic [11:0] stride;
    logic [11:0] last;
    logic [11:0] first;
  } desc_t;

  typedef struct packed {
    status_e     status;
    logic        write_op;
    logic [31:0] offset;
    logic [3:0]  len;
    logic [63:0] data;
  } item_t;

  function automatic logic [3:0] width_bit(input logic [3:0] len);
    logic [3:0] w;
    case (len)
      4'd1:    w = 4'b0001;
      4'd2:    w = 4'b0010;
      4'd4:    w = 4'b0100;
      4'd8:    w = 4'b1000;
      default: w = 4'b0000;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/mrac_if.sv =====
// channel interfaces: access in, result out, configuration write
// depends on mrac_pkg
interface mrac_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] addr;
  logic [3:0]  len;
  logic [63:0] write_data;
  modport source (output valid, action, addr, len, write_data, input ready);
  modport sink   (input valid, action, addr, len, write_data, output ready);
endinterface

interface mrac_out_if;
  logic               valid;
  logic               ready;
  mrac_pkg::status_e  status;
  logic [63:0]        read_data;
  modport source (output valid, status, read_data, input ready);
  modport sink   (input valid, status, read_data, output ready);
endinterface

interface mrac_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mrac_pkg::CfgIdxW-1:0]    index;
  logic [mrac_pkg::CfgDataW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/mrac_front.sv =====
// front part: configuration registers, length/region checks, descriptor walk
// with a shared bit-serial remainder unit; depends on mrac_pkg, mrac_if
module mrac_front #(
  parameter int unsigned DescSlots = mrac_pkg::DescSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  mrac_cfg_if.sink            cfg_i,
  mrac_in_if.sink             in_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output mrac_pkg::item_t     push_item_o
);
  import mrac_pkg::*;

  localparam int unsigned IW = $clog2(DescSlots + 1);
  localparam int unsigned DW = (DescSlots > 1) ? $clog2(DescSlots) : 1;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_DESC = 5'b00010,
    F_DIV  = 5'b00100,
    F_EVAL = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_e;

  logic [31:0]      base_q, last_q;
  logic [2:0]       in_use_q;
  logic [DescW-1:0] desc_q [DescSlots];

  fstate_e     state_q, state_d;
  item_t       item_q, item_d;
  logic        unal_q, unal_d;
  logic [3:0]  wbit_q, wbit_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [11:0] rem_q, rem_d, dvd_q, dvd_d;
  logic [3:0]  step_q, step_d;

  logic [IW-1:0] count;
  logic [2:0]    slot;
  desc_t         d;
  logic [12:0]   trial, room;
  logic [32:0]   end_addr;
  logic [3:0]    wb_in;

  assign cfg_i.ready = 1'b1;
  assign slot = cfg_i.index - CFG_DESC_0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      last_q   <= 32'd4095;
      in_use_q <= '0;
      for (int i = 0; i < DescSlots; i++) desc_q[i] <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_REGION_BASE: base_q   <= cfg_i.data[31:0];
        CFG_REGION_LAST: last_q   <= cfg_i.data[31:0];
        CFG_DESC_IN_USE: in_use_q <= cfg_i.data[2:0];
        default: begin
          if (32'(slot) < DescSlots) desc_q[slot[DW-1:0]] <= cfg_i.data[DescW-1:0];
        end
      endcase
    end
  end

  // descriptors beyond the slot count are never consulted
  assign count = (32'(in_use_q) > DescSlots) ? IW'(DescSlots) : IW'(in_use_q);
  assign d     = desc_t'(desc_q[idx_q[DW-1:0]]);
  assign trial = {rem_q, dvd_q[11]};
  assign room  = {1'b0, d.last} - {1'b0, item_q.offset[11:0]} + 13'd1;
  assign end_addr = {1'b0, in_i.addr} + 33'(in_i.len) - 33'd1;
  assign wb_in = width_bit(in_i.len);

  assign in_i.ready   = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);
  assign push_item_o  = item_q;

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    unal_d  = unal_q;
    wbit_d  = wbit_q;
    idx_d   = idx_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    step_d  = step_q;
    case (state_q)
      F_IDLE: begin
        if (in_i.valid) begin
          item_d.write_op = in_i.action;
          item_d.offset   = in_i.addr - base_q;
          item_d.len      = in_i.len;
          item_d.data     = in_i.write_data;
          wbit_d = wb_in;
          unal_d = (in_i.addr[3:0] & (in_i.len - 4'd1)) != 4'd0;
          idx_d  = '0;
          if (wb_in == 4'd0) begin
            item_d.status = ST_BAD_WIDTH;
            state_d = F_PUSH;
          end else if (in_i.addr < base_q || end_addr > {1'b0, last_q}) begin
            item_d.status = ST_OUT_REGION;
            state_d = F_PUSH;
          end else if (in_use_q == 3'd0) begin
            item_d.status = ST_OK;
            state_d = F_PUSH;
          end else begin
            item_d.status = ST_UNKNOWN;
            state_d = F_DESC;
          end
        end
      end
      F_DESC: begin
        if (idx_q == count) begin
          state_d = F_PUSH;
        end else if (item_q.offset < 32'(d.first) || item_q.offset > 32'(d.last)) begin
          idx_d = idx_q + IW'(1);
        end else if (d.stride == 12'd0) begin
          item_d.status = (d.aligned && unal_q) ? ST_MISALIGNED : ST_OUT_REG;
          idx_d = idx_q + IW'(1);
        end else begin
          // offset lies within first..last, so it fits twelve bits
          dvd_d   = item_q.offset[11:0] - d.first;
          rem_d   = '0;
          step_d  = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        dvd_d = {dvd_q[10:0], 1'b0};
        rem_d = (trial >= {1'b0, d.stride}) ? 12'(trial - {1'b0, d.stride}) : trial[11:0];
        step_d = step_q + 4'd1;
        if (step_q == 4'd11) state_d = F_EVAL;
      end
      F_EVAL: begin
        state_d = F_DESC;
        idx_d   = idx_q + IW'(1);
        if (rem_q != 12'd0) begin
          item_d.status = (d.aligned && unal_q) ? ST_MISALIGNED : ST_OUT_REG;
        end else if ({9'd0, item_q.len} > room) begin
          item_d.status = ST_OUT_REG;
        end else if ((d.widths & wbit_q) == 4'd0) begin
          item_d.status = ST_BAD_WIDTH;
        end else if (d.aligned && unal_q) begin
          item_d.status = ST_MISALIGNED;
        end else if (!d.dirs[item_q.write_op]) begin
          item_d.status = ST_DIR_DENIED;
        end else begin
          item_d.status = ST_OK;
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    unal_q <= unal_d;
    wbit_q <= wbit_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
  end

endmodule

// ===== sv/mrac_queue.sv =====
// two-entry queue of classified accesses between front and back
// depends on mrac_pkg
module mrac_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  mrac_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output mrac_pkg::item_t pop_item_o
);
  import mrac_pkg::*;

  item_t      ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = ent_q[rp_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= push_item_i;
  end

endmodule

// ===== sv/mrac_back.sv =====
// back part: byte store with clearing pass, byte-serial read and write,
// result register; depends on mrac_pkg, mrac_if
module mrac_back #(
  parameter int unsigned RegionBytes = mrac_pkg::RegionBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  mrac_pkg::item_t pop_item_i,
  mrac_out_if.source      out_o
);
  import mrac_pkg::*;

  localparam int unsigned AW = $clog2(RegionBytes);
  localparam int unsigned CW = $clog2(RegionBytes + 1);

  typedef enum logic [3:0] {
    B_CLEAR = 4'b0001,
    B_IDLE  = 4'b0010,
    B_RUN   = 4'b0100,
    B_OUT   = 4'b1000
  } bstate_e;

  logic [7:0]    mem [RegionBytes];
  logic [7:0]    rd_q;
  bstate_e       state_q;
  logic [CW-1:0] clr_q;
  item_t         cur_q;
  logic [3:0]    cnt_q;
  logic          prev_ok_q;
  logic [63:0]   acc_q;
  status_e       res_q;

  logic          we;
  logic [AW-1:0] addr;
  logic [7:0]    wdata;
  logic [32:0]   pos;
  logic          in_rng;
  logic [2:0]    k;

  assign pos    = {1'b0, cur_q.offset} + 33'(cnt_q[2:0]);
  assign in_rng = pos < 33'(RegionBytes);
  assign k      = 3'(cnt_q - 4'd1);

  always_comb begin
    we    = 1'b0;
    addr  = pos[AW-1:0];
    wdata = cur_q.data[8*cnt_q[2:0] +: 8];
    if (state_q == B_CLEAR) begin
      we    = 1'b1;
      addr  = clr_q[AW-1:0];
      wdata = 8'd0;
    end else if (state_q == B_RUN && cnt_q < cur_q.len && cur_q.write_op) begin
      we = in_rng;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    rd_q <= mem[addr];
  end

  assign pop_ready_o     = (state_q == B_IDLE);
  assign out_o.valid     = (state_q == B_OUT);
  assign out_o.status    = res_q;
  assign out_o.read_data = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        B_CLEAR: begin
          clr_q <= clr_q + CW'(1);
          if (clr_q == CW'(RegionBytes - 1)) state_q <= B_IDLE;
        end
        B_IDLE: begin
          cnt_q <= '0;
          if (pop_valid_i) state_q <= (pop_item_i.status == ST_OK) ? B_RUN : B_OUT;
        end
        B_RUN: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == cur_q.len) state_q <= B_OUT;
        end
        B_OUT: begin
          if (out_o.ready) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE) begin
      cur_q     <= pop_item_i;
      res_q     <= pop_item_i.status;
      acc_q     <= '0;
      prev_ok_q <= 1'b0;
    end else if (state_q == B_RUN) begin
      // read data of the previous byte arrives in the cycle after its address
      prev_ok_q <= in_rng && !cur_q.write_op && (cnt_q < cur_q.len);
      if (cnt_q != 4'd0 && prev_ok_q) acc_q[8*k +: 8] <= rd_q;
    end
  end

endmodule

// ===== sv/mmio_register_access_check.sv =====
// top level of the bus register access checker
// depends on mrac_pkg, mrac_if, mrac_front, mrac_queue, mrac_back
//
// Checks each bus transfer (read or write, address, length, data) against a
// device region and up to DescSlots register descriptors, then carries out
// accepted accesses on a byte store of RegionBytes entries. After reset the
// store (4096 bytes by default) is cleared one byte a cycle; results wait
// until that pass ends, configuration writes are taken at once. The front
// part takes one access at a time: one rejected by length or region or with
// no descriptors in use goes straight to its push state, otherwise the
// descriptors are walked in turn, and each covering one with a stride
// passes through the 12-step bit-serial remainder unit for the stride test.
// The back part handles an accepted access over one store port, one byte a
// cycle, and passes a rejected one straight on to its result register. A
// two-entry queue between the parts lets the front classify the next
// transfer while the back is busy or its result is stalled.
module mmio_register_access_check #(
  parameter int unsigned RegionBytes = mrac_pkg::RegionBytesDef,
  parameter int unsigned DescSlots   = mrac_pkg::DescSlotsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrac_cfg_if.sink   cfg_i,
  mrac_in_if.sink    in_i,
  mrac_out_if.source out_o
);
  import mrac_pkg::*;

  // classified transfer from front into the queue
  logic  f_valid, f_ready;
  item_t f_item;
  // queue head towards the back
  logic  b_valid, b_ready;
  item_t b_item;

  mrac_front #(.DescSlots(DescSlots)) u_front (
    .clk_i, .rst_ni, .cfg_i, .in_i,
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .push_item_o  (f_item)
  );

  mrac_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  mrac_back #(.RegionBytes(RegionBytes)) u_back (
    .clk_i, .rst_ni,
    .pop_valid_i (b_valid),
    .pop_ready_o (b_ready),
    .pop_item_i  (b_item),
    .out_o
  );

endmodule

// ===== sv/mrac_checker.sv =====
// port-level assertions on the result channel, bound to the top level
// depends on mrac_pkg, mmio_register_access_check
module mrac_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid,
  input logic              out_ready,
  input mrac_pkg::status_e out_status,
  input logic [63:0]       out_data
);
  import mrac_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_data))
    else $error("stalled result changed");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status != ST_OK |-> out_data == 64'd0)
    else $error("rejected access returned data");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_status != 3'd7)
    else $error("undefined status code");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid)
    else $error("result shown straight after reset");

endmodule

bind mmio_register_access_check mrac_checker u_mrac_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_status (out_o.status),
  .out_data   (out_o.read_data)
);

// ===== tb/mrac_access_scoreboard.sv =====
// access predictor and expected-result store for the register access checker
// depends on mrac_pkg
class mrac_access_scoreboard;

  localparam int unsigned StoreBytes = mrac_pkg::RegionBytesDef;

  typedef struct {
    mrac_pkg::status_e status;
    logic [63:0]       read_data;
  } outcome_t;

  logic [31:0]     base;
  logic [31:0]     last_addr;
  logic [2:0]      in_use;
  mrac_pkg::desc_t descs [5];
  logic [7:0]      store [StoreBytes];
  outcome_t        pending [$];
  int              mismatches;
  int              checked;
  int              ok_count;

  function void clear();
    base = 32'd0;
    last_addr = 32'd4095;
    in_use = 3'd0;
    foreach (descs[i]) descs[i] = '0;
    foreach (store[i]) store[i] = 8'h00;
    pending.delete();
    mismatches = 0;
    checked = 0;
    ok_count = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [42:0] value);
    case (idx)
      mrac_pkg::CFG_REGION_BASE: base = value[31:0];
      mrac_pkg::CFG_REGION_LAST: last_addr = value[31:0];
      mrac_pkg::CFG_DESC_IN_USE: in_use = value[2:0];
      default: descs[idx - mrac_pkg::CFG_DESC_0] = value;
    endcase
  endfunction

  // classification of one access against region and descriptor table
  function mrac_pkg::status_e classify(logic [31:0] addr, logic [3:0] len, logic wr);
    logic [3:0]        wbit;
    logic [32:0]       tail;
    logic [31:0]       offset;
    logic              unaligned;
    int unsigned       count;
    mrac_pkg::status_e verdict;
    mrac_pkg::desc_t   d;
    wbit = 4'd0;
    case (len)
      4'd1: wbit = 4'b0001;
      4'd2: wbit = 4'b0010;
      4'd4: wbit = 4'b0100;
      4'd8: wbit = 4'b1000;
      default: wbit = 4'd0;
    endcase
    if (wbit == 4'd0) return mrac_pkg::ST_BAD_WIDTH;
    tail = {1'b0, addr} + len - 33'd1;
    if (addr < base || tail > {1'b0, last_addr}) return mrac_pkg::ST_OUT_REGION;
    if (in_use == 3'd0) return mrac_pkg::ST_OK;
    offset = addr - base;
    unaligned = (addr & (len - 32'd1)) != 32'd0;
    count = (in_use > 3'd5) ? 5 : in_use;
    verdict = mrac_pkg::ST_UNKNOWN;
    for (int i = 0; i < count; i++) begin
      d = descs[i];
      if (offset < d.first || offset > d.last) continue;
      if (d.stride == 12'd0 || ((offset - d.first) % d.stride) != 0) begin
        verdict = (d.aligned && unaligned) ? mrac_pkg::ST_MISALIGNED : mrac_pkg::ST_OUT_REG;
        continue;
      end
      if (len > d.last - offset + 1) begin
        verdict = mrac_pkg::ST_OUT_REG;
        continue;
      end
      if ((d.widths & wbit) == 4'd0) begin
        verdict = mrac_pkg::ST_BAD_WIDTH;
        continue;
      end
      if (d.aligned && unaligned) begin
        verdict = mrac_pkg::ST_MISALIGNED;
        continue;
      end
      if (!d.dirs[wr ? 1 : 0]) begin
        verdict = mrac_pkg::ST_DIR_DENIED;
        continue;
      end
      return mrac_pkg::ST_OK;
    end
    return verdict;
  endfunction

  // note one access transfer and queue its expected result
  function void note_access(logic wr, logic [31:0] addr, logic [3:0] len, logic [63:0] wdata);
    outcome_t    o;
    logic [31:0] offset;
    longint unsigned pos;
    o.status = classify(addr, len, wr);
    o.read_data = 64'd0;
    if (o.status == mrac_pkg::ST_OK) begin
      ok_count++;
      offset = addr - base;
      for (int i = 0; i < len && i < 8; i++) begin
        pos = longint'(offset) + i;
        if (pos >= StoreBytes) continue;
        if (wr) store[pos] = wdata[8*i +: 8];
        else o.read_data[8*i +: 8] = store[pos];
      end
    end
    if (wr) o.read_data = 64'd0;
    pending.push_back(o);
  endfunction

  // compare one result transfer with the oldest expectation
  function void check_result(mrac_pkg::status_e status, logic [63:0] rdata);
    outcome_t o;
    checked++;
    if (pending.size() == 0) begin
      $error("unexpected result: status %0d read_data %h", status, rdata);
      mismatches++;
      return;
    end
    o = pending.pop_front();
    if (status !== o.status) begin
      $error("status: expected %0d, actual %0d", o.status, status);
      mismatches++;
    end
    if (rdata !== o.read_data) begin
      $error("read_data: expected %h, actual %h", o.read_data, rdata);
      mismatches++;
    end
  endfunction

endclass

// ===== tb/mmio_register_access_check_test.sv =====
// testbench top of the register access checker: directed and random accesses
// over several region and descriptor settings, checked by a scoreboard class
// depends on mrac_pkg, mrac_if, mrac_access_scoreboard and the block itself
module mmio_register_access_check_test;
  import mrac_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  mrac_cfg_if cfg_if ();
  mrac_in_if  in_if ();
  mrac_out_if out_if ();

  mmio_register_access_check dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if.sink),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  mrac_access_scoreboard board;
  int unsigned cycles;
  int unsigned sent;
  bit          quiet_sink;  // a stretch with no stalls on the result side

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.action = 1'b0;
    in_if.addr = '0;
    in_if.len = '0;
    in_if.write_data = '0;
    out_if.ready = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stall per transfer, sampled at the rising edge
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = quiet_sink ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      board.check_result(out_if.status, out_if.read_data);
      @(negedge clk_i);
    end
  end

  // one configuration register write transfer
  task automatic write_reg(logic [2:0] idx, logic [42:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    board.write_reg(idx, value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // one access transfer, with a random hold-off unless gapless;
  // valid stays up after the transfer until the next hold-off or drain
  task automatic send_access(logic wr, logic [31:0] addr, logic [3:0] len,
                             logic [63:0] wdata, bit gapless);
    int unsigned gap;
    gap = gapless ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.action <= wr;
    in_if.addr <= addr;
    in_if.len <= len;
    in_if.write_data <= wdata;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_access(wr, addr, len, wdata);
    sent++;
    @(negedge clk_i);
  endtask

  // wait for every result, then let the back end settle before reconfiguring
  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  function automatic logic [42:0] make_desc(logic [11:0] first, logic [11:0] last,
      logic [11:0] stride, logic [3:0] widths, logic [1:0] dirs, logic aligned);
    desc_t d;
    d.first = first;
    d.last = last;
    d.stride = stride;
    d.widths = widths;
    d.dirs = dirs;
    d.aligned = aligned;
    return d;
  endfunction

  function automatic logic [3:0] pick_len();
    case ($urandom_range(0, 9))
      0: return 4'd1;
      1, 2: return 4'd2;
      3, 4, 5: return 4'd4;
      6, 7, 8: return 4'd8;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random table entry, mostly covering a region of the given span
  function automatic logic [42:0] rand_desc(int unsigned span);
    logic [11:0] f;
    logic [11:0] l;
    f = 12'($urandom_range(0, span - 1));
    l = 12'($urandom_range(f, span - 1 > f + 64 ? f + 64 : span - 1));
    if ($urandom_range(0, 9) == 0) return 43'({$urandom, $urandom});
    return make_desc(f, l, 12'($urandom_range(0, 9)), 4'($urandom),
                     2'($urandom), 1'($urandom));
  endfunction

  // one random phase: setup, then accesses aimed mostly inside the region
  task automatic random_phase(logic [31:0] base, logic [31:0] last_addr, int n);
    int unsigned span;
    logic [31:0] addr;
    bit          gapless;
    write_reg(CFG_REGION_BASE, base);
    write_reg(CFG_REGION_LAST, last_addr);
    span = (last_addr >= base) ? last_addr - base + 1 : 64;
    if (span > 4096) span = 4096;
    for (int i = 0; i < 5; i++) write_reg(3'(CFG_DESC_0 + i), rand_desc(span));
    write_reg(CFG_DESC_IN_USE, 3'($urandom_range(0, 7)));
    for (int i = 0; i < n; i++) begin
      gapless = (i % 40) < 8;
      quiet_sink = gapless;
      case ($urandom_range(0, 9))
        0: addr = $urandom;
        1: addr = last_addr - 32'($urandom_range(0, 9));
        2: addr = base - 32'($urandom_range(1, 4));
        default: addr = base + 32'($urandom_range(0, span - 1));
      endcase
      send_access(1'($urandom), addr, pick_len(), rand64(), gapless);
    end
    quiet_sink = 1'b0;
    drain();
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // no policy: default region accepted, store round trips, region end and bad lengths rejected
    send_access(1'b1, 32'h0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_access(1'b0, 32'h0, 4'd8, 64'h0, 1'b0);
    send_access(1'b1, 32'd4088, 4'd8, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_access(1'b0, 32'd4092, 4'd4, 64'h0, 1'b0);
    send_access(1'b0, 32'd4093, 4'd4, 64'h0, 1'b0);   // past the region end
    send_access(1'b1, 32'hFFFF_FFFF, 4'd1, 64'hAA, 1'b0);
    send_access(1'b0, 32'h10, 4'd3, 64'h0, 1'b0);     // bad length
    send_access(1'b1, 32'h10, 4'd0, 64'h0, 1'b0);
    send_access(1'b0, 32'h10, 4'd15, 64'h0, 1'b0);
    drain();

    // table: stride grid, zero stride, widths, alignment, direction
    write_reg(CFG_REGION_BASE, 32'h1000_0001);
    write_reg(CFG_REGION_LAST, 32'h1000_1000);        // span equal to the store size
    write_reg(3'(CFG_DESC_0), make_desc(12'h0, 12'h3F, 12'h8, 4'b1100, 2'b01, 1'b1));
    write_reg(3'(CFG_DESC_0 + 1), make_desc(12'h0, 12'h3F, 12'h4, 4'b1111, 2'b10, 1'b0));
    write_reg(3'(CFG_DESC_0 + 2), make_desc(12'h40, 12'h4F, 12'h0, 4'b1111, 2'b11, 1'b1));
    write_reg(3'(CFG_DESC_0 + 3), make_desc(12'h50, 12'h53, 12'h1, 4'b0001, 2'b11, 1'b0));
    write_reg(3'(CFG_DESC_0 + 4), make_desc(12'hFF8, 12'hFFF, 12'h1, 4'b1111, 2'b11, 1'b0));
    write_reg(CFG_DESC_IN_USE, 3'd7);                 // saturates to five
    send_access(1'b1, 32'h1000_0001, 4'd8, 64'hDEAD_BEEF_0BAD_F00D, 1'b0);
    send_access(1'b0, 32'h1000_0001, 4'd8, 64'h0, 1'b0);
    send_access(1'b1, 32'h1000_0005, 4'd4, 64'h1234_5678, 1'b0);
    send_access(1'b0, 32'h1000_0003, 4'd2, 64'h0, 1'b0);
    send_access(1'b0, 32'h1000_0041, 4'd4, 64'h0, 1'b0);
    send_access(1'b0, 32'h1000_0042, 4'd4, 64'h0, 1'b0);
    send_access(1'b1, 32'h1000_0052, 4'd2, 64'h0, 1'b0);
    send_access(1'b1, 32'h1000_0053, 4'd1, 64'h77, 1'b0);
    send_access(1'b0, 32'h1000_0060, 4'd1, 64'h0, 1'b0);
    send_access(1'b1, 32'h1000_0FF9, 4'd8, 64'hFEDC_BA98_7654_3210, 1'b0);
    send_access(1'b0, 32'h1000_0FF9, 4'd8, 64'h0, 1'b0);
    send_access(1'b0, 32'h1000_0000, 4'd1, 64'h0, 1'b0);
    drain();

    // inverted region rejects everything
    write_reg(CFG_REGION_BASE, 32'hFFFF_FFFF);
    write_reg(CFG_REGION_LAST, 32'h0);
    send_access(1'b0, 32'hFFFF_FFFF, 4'd1, 64'h0, 1'b0);
    send_access(1'b1, 32'h0, 4'd1, 64'h0, 1'b0);
    drain();

    // random phases over several region settings, extremes included
    random_phase(32'h0, 32'd4095, 150);
    random_phase(32'h8000_0000, 32'h8000_00FF, 150);
    random_phase(32'hFFFF_F000, 32'hFFFF_FFFF, 130);
    random_phase(32'h0000_1234, 32'h0000_1273, 130);
    random_phase(32'h2000_0000, 32'h2000_1FFF, 100);
    random_phase(32'h0000_0100, 32'h0000_00FF, 30);

    $display("covered %0d access transfers, %0d accepted, %0d results checked",
             sent, board.ok_count, board.checked);
    $display("region and descriptor settings varied over nine phases");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mrac_pkg.sv
sv/mrac_if.sv
sv/mrac_front.sv
sv/mrac_queue.sv
sv/mrac_back.sv
sv/mmio_register_access_check.sv
sv/mrac_checker.sv
tb/mrac_access_scoreboard.sv
tb/mmio_register_access_check_test.sv
